@@ rtl/dpt_pkg.sv @@
// Package of shared constants and the witness base table for the primality tester.
package dpt_pkg;

  localparam int unsigned CAND_BITS  = 63;
  localparam int unsigned BASE_BITS  = 64;
  localparam int unsigned BASE_COUNT = 7;
  localparam int unsigned KIDX_BITS  = 3;

  // Witness bases of the deterministic test, in the order they are tried.
  function automatic logic [BASE_BITS-1:0] witness_base(input logic [KIDX_BITS-1:0] idx);
    logic [BASE_BITS-1:0] b;
    case (idx)
      3'd0:    b = 64'd2;
      3'd1:    b = 64'd325;
      3'd2:    b = 64'd9375;
      3'd3:    b = 64'd28178;
      3'd4:    b = 64'd450775;
      3'd5:    b = 64'd9780504;
      3'd6:    b = 64'd1795265022;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/dpt_cand_if.sv @@
// Channel interface that carries one candidate item.
interface dpt_cand_if;
  logic                           valid;
  logic                           ready;
  logic [dpt_pkg::CAND_BITS-1:0]  candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

@@ rtl/dpt_result_if.sv @@
// Channel interface that carries one primality result item.
interface dpt_result_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

@@ rtl/deterministic_primality_test.sv @@
// Work: zero, one, two and even items are settled without the multiplier; otherwise each
// modular product runs through the bit-cell multiplier, up to 125 products per base and
// seven bases.
// Throughput: one item at a time; the next item is taken once the previous result is
// registered, while that result may still wait on the output.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module deterministic_primality_test #(
  parameter int unsigned VALUE_BITS = 63
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  dpt_cand_if.sink        cand_i,
  dpt_result_if.source    result_o
);

  localparam int unsigned W = VALUE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_ODD, S_BASE, S_PSTEP, S_PMUL1, S_PMUL2, S_SCHK, S_SQ, S_RES
  } state_e;

  state_e                          state_q;
  logic [W-1:0]                    n_q;
  logic [W-1:0]                    last_q;
  logic [W-1:0]                    m_q;
  logic [W-1:0]                    acc_q;
  logic [W-1:0]                    sq_q;
  logic [W-1:0]                    e_q;
  logic [W-1:0]                    ex_q;
  logic [dpt_pkg::KIDX_BITS-1:0]   k_q;
  logic                            res_q;
  logic                            out_valid_q;
  logic                            out_prime_q;
  logic                            start_q;
  logic [W-1:0]                    mul_a_q;
  logic [W-1:0]                    mul_b_q;
  logic                            mul_done;
  logic [W-1:0]                    mul_prod;
  logic [W-1:0]                    n_in;
  logic [dpt_pkg::BASE_BITS-1:0]   base;

  assign n_in = cand_i.candidate[W-1:0];
  assign base = dpt_pkg::witness_base(k_q);

  assign cand_i.ready    = (state_q == S_IDLE);
  assign result_o.valid  = out_valid_q;
  assign result_o.is_prime = out_prime_q;

  dpt_mulmod #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .n_i     (n_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      last_q      <= '0;
      m_q         <= '0;
      acc_q       <= '0;
      sq_q        <= '0;
      e_q         <= '0;
      ex_q        <= '0;
      k_q         <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_prime_q <= 1'b0;
      start_q     <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cand_i.valid) begin
            n_q    <= n_in;
            last_q <= n_in - 1'b1;
            m_q    <= n_in - 1'b1;
            if (n_in == W'(2)) begin
              res_q   <= 1'b1;
              state_q <= S_RES;
            end else if (n_in < W'(2) || !n_in[0]) begin
              res_q   <= 1'b0;
              state_q <= S_RES;
            end else begin
              state_q <= S_ODD;
            end
          end
        end
        S_ODD: begin
          // Strip the factors of two from n-1.
          if (m_q[0]) begin
            k_q     <= '0;
            state_q <= S_BASE;
          end else begin
            m_q <= m_q >> 1;
          end
        end
        S_BASE: begin
          if (k_q == dpt_pkg::KIDX_BITS'(dpt_pkg::BASE_COUNT) ||
              base >= dpt_pkg::BASE_BITS'(n_q)) begin
            res_q   <= 1'b1;
            state_q <= S_RES;
          end else begin
            acc_q   <= W'(1);
            sq_q    <= base[W-1:0];
            e_q     <= m_q;
            state_q <= S_PSTEP;
          end
        end
        S_PSTEP: begin
          if (e_q == '0) begin
            ex_q    <= m_q;
            state_q <= S_SCHK;
          end else if (e_q[0]) begin
            mul_a_q <= acc_q;
            mul_b_q <= sq_q;
            start_q <= 1'b1;
            state_q <= S_PMUL1;
          end else begin
            mul_a_q <= sq_q;
            mul_b_q <= sq_q;
            start_q <= 1'b1;
            state_q <= S_PMUL2;
          end
        end
        S_PMUL1: begin
          if (mul_done) begin
            acc_q   <= mul_prod;
            mul_a_q <= sq_q;
            mul_b_q <= sq_q;
            start_q <= 1'b1;
            state_q <= S_PMUL2;
          end
        end
        S_PMUL2: begin
          if (mul_done) begin
            sq_q    <= mul_prod;
            e_q     <= e_q >> 1;
            state_q <= S_PSTEP;
          end
        end
        S_SCHK: begin
          if (ex_q == last_q || acc_q == W'(1) || acc_q == last_q) begin
            if (acc_q != last_q && !ex_q[0]) begin
              res_q   <= 1'b0;
              state_q <= S_RES;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_BASE;
            end
          end else begin
            ex_q    <= ex_q << 1;
            mul_a_q <= acc_q;
            mul_b_q <= acc_q;
            start_q <= 1'b1;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            acc_q   <= mul_prod;
            state_q <= S_SCHK;
          end
        end
        S_RES: begin
          // Hold the verdict until the output register is free.
          if (!out_valid_q || result_o.ready) begin
            out_valid_q <= 1'b1;
            out_prime_q <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/dpt_cell.sv @@
// One bit-slice of the modular accumulator: holds a bit, adds and trial-subtracts.
module dpt_cell (
  input  logic clk_i,
  input  logic clear_i,
  input  logic step_i,
  input  logic sel_i,
  input  logic add_i,
  input  logic mod_i,
  input  logic carry_i,
  input  logic borrow_i,
  output logic acc_o,
  output logic carry_o,
  output logic borrow_o
);

  logic acc_q;
  logic acc_d;
  logic sum;
  logic diff;

  assign sum      = acc_q ^ add_i ^ carry_i;
  assign carry_o  = (acc_q & add_i) | (acc_q & carry_i) | (add_i & carry_i);
  assign diff     = sum ^ mod_i ^ borrow_i;
  assign borrow_o = (~sum & mod_i) | (~(sum ^ mod_i) & borrow_i);
  assign acc_o    = acc_q;

  // Keep the reduced sum when the whole chain reports sum >= modulus.
  assign acc_d = sel_i ? diff : sum;

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      acc_q <= 1'b0;
    end else if (step_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

@@ rtl/dpt_mulmod.sv @@
// Shift-and-add modular multiplier built from a row of accumulator bit cells.
module dpt_mulmod #(
  parameter int unsigned W = 63
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] n_i,
  output logic         done_o,
  output logic [W-1:0] prod_o
);

  localparam int unsigned CNT_BITS = $clog2(W);

  logic [W-1:0]        a_q;
  logic [W-1:0]        b_q;
  logic [W-1:0]        n_q;
  logic                busy_q;
  logic                phase_q;
  logic                done_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [W-1:0]        addend;
  logic [W:0]          carry;
  logic [W:0]          borrow;
  logic                sel;

  // Phase zero doubles the accumulator, phase one adds a when the multiplier bit is set.
  assign addend    = phase_q ? (b_q[W-1] ? a_q : '0) : prod_o;
  assign carry[0]  = 1'b0;
  assign borrow[0] = 1'b0;
  assign sel       = carry[W] | ~borrow[W];

  for (genvar i = 0; i < W; i++) begin : g_cell
    dpt_cell u_cell (
      .clk_i    (clk_i),
      .clear_i  (start_i),
      .step_i   (busy_q),
      .sel_i    (sel),
      .add_i    (addend[i]),
      .mod_i    (n_q[i]),
      .carry_i  (carry[i]),
      .borrow_i (borrow[i]),
      .acc_o    (prod_o[i]),
      .carry_o  (carry[i+1]),
      .borrow_o (borrow[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      n_q <= n_i;
      b_q <= b_i;
    end else if (busy_q && phase_q) begin
      b_q <= {b_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= CNT_BITS'(W - 1);
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          if (cnt_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
      end
    end
  end

  assign done_o = done_q;

endmodule

@@ rtl/dpt_checker.sv @@
// Port-level checker for the primality tester, bound to the top level.
module dpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic is_prime_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(is_prime_i))
    else $error("result item dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in work");

  a_ready_falls_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("input ready dropped without an item taken");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result shown while input still busy");

endmodule

bind deterministic_primality_test dpt_checker u_dpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cand_i.valid),
  .in_ready_i  (cand_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .is_prime_i  (result_o.is_prime)
);

@@ verif/tb.sv @@
// Testbench for the deterministic primality tester: scoreboard against its own predictor.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned VALUE_BITS = 63;
  localparam int unsigned STALL_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum int unsigned {
    PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH
  } phase_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  dpt_cand_if   cand_if ();
  dpt_result_if result_if ();

  deterministic_primality_test #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cand_i   (cand_if.sink),
    .result_o (result_if.source)
  );

  logic [dpt_pkg::CAND_BITS-1:0] pending_cands[$];
  logic                          expected_verdicts[$];
  int unsigned                   n_items;
  int unsigned                   n_taken;
  int unsigned                   n_errors;
  int unsigned                   quiet_cycles;
  bit                            stim_ready;
  phase_e                        phase;

  localparam logic [63:0] WITNESSES[7] = '{64'd2, 64'd325, 64'd9375, 64'd28178,
                                           64'd450775, 64'd9780504, 64'd1795265022};

  function automatic logic [62:0] mod_mul(logic [62:0] a, logic [62:0] b, logic [62:0] n);
    logic [125:0] prod;
    prod = {63'd0, a} * {63'd0, b};
    return 63'(prod % {63'd0, n});
  endfunction

  function automatic logic [62:0] mod_pow(logic [62:0] base, logic [62:0] e, logic [62:0] n);
    logic [62:0] acc;
    logic [62:0] sq;
    acc = 63'd1;
    sq  = base;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, sq, n);
      sq = mod_mul(sq, sq, n);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic primality(logic [62:0] n);
    logic [62:0] odd_part;
    logic [62:0] last;
    logic [62:0] ex;
    logic [62:0] r;
    logic [63:0] a;
    if (n == 63'd2) return 1'b1;
    if (n < 63'd2 || !n[0]) return 1'b0;
    last = n - 63'd1;
    odd_part = last;
    while (!odd_part[0]) odd_part = odd_part >> 1;
    for (int k = 0; k < 7; k++) begin
      a = WITNESSES[k];
      if (a >= {1'b0, n}) break;
      ex = odd_part;
      r  = mod_pow(a[62:0], ex, n);
      while (ex != last && r != 63'd1 && r != last) begin
        ex = ex << 1;
        r  = mod_mul(r, r, n);
      end
      if (r != last && !ex[0]) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus: directed corner values, then mostly cheap small candidates
  initial begin
    logic [dpt_pkg::CAND_BITS-1:0] c;
    int unsigned                   pick;
    pending_cands = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd9, 63'd25,
                      63'd325, 63'd327, 63'd341, 63'd561, 63'd2047, 63'd9377,
                      63'd3215031751, 63'd1795265023, 63'd4294967291, 63'd1000000007,
                      63'h7fff_ffff_ffff_ffff, 63'h7fff_ffff_ffff_fffe,
                      63'd9223372036854775783, 63'd2305843009213693951,
                      63'd999999999989};
    for (int i = 0; i < 77; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) c = 63'($urandom_range(0, 65535));
      else if (pick < 80) c = 63'($urandom);
      else c = 63'({$urandom, $urandom});
      if (pick % 3 != 0 && c != 63'd2) c[0] = 1'b1;
      pending_cands = {pending_cands, c};
    end
    n_items = pending_cands.size();
    stim_ready = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cands.size() == 0 && n_taken == n_items && expected_verdicts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  always_comb begin
    if (n_items == 0 || n_taken >= n_items) phase = PH_BOTH;
    else phase = phase_e'((n_taken * 4) / n_items);
  end

  // Driver: hold the item until taken, idle at random in the sender phases
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_if.valid     <= 1'b0;
      cand_if.candidate <= '0;
    end else if (!cand_if.valid || cand_if.ready) begin
      if (stim_ready && pending_cands.size() != 0 &&
          !((phase == PH_SRC_IDLE && $urandom_range(0, 99) < 82) ||
            (phase == PH_BOTH && $urandom_range(0, 99) < 16))) begin
        cand_if.valid     <= 1'b1;
        cand_if.candidate <= pending_cands.pop_front();
      end else begin
        cand_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= !((phase == PH_SNK_STALL && $urandom_range(0, 99) < 82) ||
                           (phase == PH_BOTH && $urandom_range(0, 99) < 16));
    end
  end

  // Monitor: predict on each taken candidate, compare each delivered verdict
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cand_if.valid && cand_if.ready) begin
        expected_verdicts = {expected_verdicts, primality(cand_if.candidate)};
        n_taken <= n_taken + 1;
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("is_prime: no item outstanding, got %0b", result_if.is_prime);
          n_errors <= n_errors + 1;
        end else if (expected_verdicts[0] !== result_if.is_prime) begin
          $error("is_prime: expected %0b, got %0b", expected_verdicts[0], result_if.is_prime);
          n_errors <= n_errors + 1;
          void'(expected_verdicts.pop_front());
        end else begin
          void'(expected_verdicts.pop_front());
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((cand_if.valid && cand_if.ready) || (result_if.valid && result_if.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
